FILE: sv/skcb_pkg.sv
// Package for the keyed byte cipher: constants, datapath command codes,
// controller state type and the command struct.
// No dependencies.
package skcb_pkg;

  localparam int unsigned INDEX_WIDTH = 32;

  localparam logic [63:0] GOLDEN_GAMMA  = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_MUL_A     = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_MUL_B     = 64'h94D0_49BB_1331_11EB;
  localparam logic [7:0]  KEY_BYTE_FLIP = 8'hAA;

  // Partial product steps of one 64x64 low-half multiply.
  localparam logic [1:0] STEP_LL  = 2'd0;  // a_lo * b_lo
  localparam logic [1:0] STEP_LH  = 2'd1;  // a_lo * b_hi
  localparam logic [1:0] STEP_HL  = 2'd2;  // a_hi * b_lo
  localparam logic [1:0] STEP_ACC = 2'd3;  // final accumulate

  // Which multiply of the chain is running.
  localparam logic [1:0] MUL_GAMMA = 2'd0;
  localparam logic [1:0] MUL_MIX_A = 2'd1;
  localparam logic [1:0] MUL_MIX_B = 2'd2;

  typedef enum logic [2:0] {
    DP_NONE,
    DP_LOAD,
    DP_MUL,
    DP_NEXT,
    DP_FIN
  } dp_op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_NEXT,
    S_FIN
  } state_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] step;
    logic [1:0] mul_idx;
  } cmd_t;

endpackage

FILE: sv/skcb_if.sv
// Valid/ready channel interfaces for the cipher's input and output bytes.
// No dependencies.
interface cipher_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_in;
  logic       last_in;

  modport source (output valid, output data_in, output last_in, input ready);
  modport sink (input valid, input data_in, input last_in, output ready);
endinterface

interface cipher_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;
  logic       last_out;

  modport source (output valid, output data_out, output last_out, input ready);
  modport sink (input valid, input data_out, input last_out, output ready);
endinterface

FILE: sv/skcb_ctrl.sv
// Controller FSM for the keyed byte cipher: sequences load, three shared
// multiplies and the finish step. Depends on skcb_pkg.
module skcb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output skcb_pkg::cmd_t cmd_o
);
  import skcb_pkg::*;

  state_e     state_q, state_d;
  logic [1:0] step_q, step_d;
  logic [1:0] mul_q, mul_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state and counters.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    mul_d   = mul_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_MUL;
          step_d  = STEP_LL;
          mul_d   = MUL_GAMMA;
        end
      end
      S_MUL: begin
        if (step_q == STEP_ACC) begin
          state_d = (mul_q == MUL_MIX_B) ? S_FIN : S_NEXT;
        end else begin
          step_d = step_q + 2'd1;
        end
      end
      S_NEXT: begin
        state_d = S_MUL;
        step_d  = STEP_LL;
        mul_d   = mul_q + 2'd1;
      end
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o.op      = DP_NONE;
    cmd_o.step    = step_q;
    cmd_o.mul_idx = mul_q;
    in_ready_o    = 1'b0;
    out_valid_d   = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = DP_LOAD;
      end
      S_MUL: begin
        cmd_o.op = DP_MUL;
      end
      S_NEXT: begin
        cmd_o.op = DP_NEXT;
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.op    = DP_FIN;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        cmd_o.op = DP_NONE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= STEP_LL;
      mul_q       <= MUL_GAMMA;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      mul_q       <= mul_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: sv/skcb_datapath.sv
// Datapath for the keyed byte cipher: key register, position counter,
// shared 32x32 multiplier with accumulator, mask and output byte.
// Depends on skcb_pkg.
module skcb_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [63:0]    cfg_wdata_i,
  input  skcb_pkg::cmd_t cmd_i,
  input  logic [7:0]     data_in_i,
  input  logic           last_in_i,
  output logic [7:0]     data_out_o,
  output logic           last_out_o
);
  import skcb_pkg::*;

  logic [63:0]            key_q;
  logic [INDEX_WIDTH-1:0] pos_q, pos_d;
  logic [2:0]             lane_q;
  logic [7:0]             data_q;
  logic                   last_q;
  logic [63:0]            a_q, a_d;
  logic [63:0]            b_q, b_d;
  logic [63:0]            pp_q, pp_d;
  logic [63:0]            acc_q, acc_d;
  logic [7:0]             out_data_q, out_data_d;
  logic                   out_last_q;

  logic [31:0] mul_x, mul_y;
  logic [63:0] mul_p;
  logic [63:0] z0, w;
  logic [2:0]  lane0, lane1, lane2;
  logic [7:0]  mask, add_b, sub_b;

  // Control registers: key and run position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
      pos_q <= '0;
    end else begin
      if (cfg_we_i) key_q <= cfg_wdata_i;
      pos_q <= pos_d;
    end
  end

  always_comb begin
    pos_d = pos_q;
    if (cmd_i.op == DP_LOAD) begin
      pos_d = last_in_i ? '0 : pos_q + INDEX_WIDTH'(1);
    end
  end

  // Shared multiplier operand select.
  always_comb begin
    case (cmd_i.step)
      STEP_LH: begin
        mul_x = a_q[31:0];
        mul_y = b_q[63:32];
      end
      STEP_HL: begin
        mul_x = a_q[63:32];
        mul_y = b_q[31:0];
      end
      default: begin
        mul_x = a_q[31:0];
        mul_y = b_q[31:0];
      end
    endcase
  end

  assign mul_p = {32'd0, mul_x} * {32'd0, mul_y};

  assign z0 = key_q ^ acc_q;
  assign w  = acc_q ^ (acc_q >> 31);

  always_comb begin
    a_d   = a_q;
    b_d   = b_q;
    pp_d  = pp_q;
    acc_d = acc_q;
    case (cmd_i.op)
      DP_LOAD: begin
        a_d = 64'(pos_q);
        b_d = GOLDEN_GAMMA;
      end
      DP_MUL: begin
        case (cmd_i.step)
          STEP_LL: begin
            pp_d = mul_p;
          end
          STEP_LH: begin
            pp_d  = {mul_p[31:0], 32'd0};
            acc_d = pp_q;
          end
          STEP_HL: begin
            pp_d  = {mul_p[31:0], 32'd0};
            acc_d = acc_q + pp_q;
          end
          default: begin
            acc_d = acc_q + pp_q;
          end
        endcase
      end
      DP_NEXT: begin
        if (cmd_i.mul_idx == MUL_GAMMA) begin
          a_d = z0 ^ (z0 >> 30);
          b_d = MIX_MUL_A;
        end else begin
          a_d = acc_q ^ (acc_q >> 27);
          b_d = MIX_MUL_B;
        end
      end
      default: begin
        a_d = a_q;
      end
    endcase
  end

  // Mask lanes wrap mod 8.
  assign lane0 = lane_q;
  assign lane1 = lane_q + 3'd3;
  assign lane2 = lane_q + 3'd7;
  assign mask  = 8'(w >> {lane0, 3'b000}) ^ 8'(w >> {lane1, 3'b000})
               ^ 8'(w >> {lane2, 3'b000});
  assign add_b = key_q[15:8];
  assign sub_b = key_q[7:0] ^ KEY_BYTE_FLIP;
  assign out_data_d = (data_q + add_b - sub_b) ^ mask;

  // Payload registers.
  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    pp_q  <= pp_d;
    acc_q <= acc_d;
    if (cmd_i.op == DP_LOAD) begin
      lane_q <= pos_q[2:0];
      data_q <= data_in_i;
      last_q <= last_in_i;
    end
    if (cmd_i.op == DP_FIN) begin
      out_data_q <= out_data_d;
      out_last_q <= last_q;
    end
  end

  assign data_out_o = out_data_q;
  assign last_out_o = out_last_q;

endmodule

FILE: sv/splitmix_keyed_byte_cipher_top.sv
// Top level of the keyed byte cipher: joins the controller and datapath
// to the byte channels and the key port. Depends on skcb_pkg, skcb_if.
//
// Decrypts one byte per beat under a 64-bit key. For the byte at run
// position i the key is XORed with i * 0x9E3779B97F4A7C15 and run through
// the splitmix64 finalizer; three bytes of that word (lanes i, i+3, i+7
// mod 8) XOR into a mask, and the output is
// (byte + key[15:8] - (key[7:0] ^ 0xAA)) ^ mask. The position counts from
// zero, wraps at 2^INDEX_WIDTH and restarts after a beat marked last.
// A new byte is taken only once the last one has finished. The three
// 64-bit products of the mix chain share one 32x32 multiplier, each
// built from three partial products plus the final accumulate, with an
// operand-load step between products, a load step before them and a
// finish step after. A finished byte sits in the output register while
// the next byte is taken in; the block only waits at the finish step if
// that register is still full. Write the key only while no byte is in
// flight; it resets to zero.
module splitmix_keyed_byte_cipher_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [63:0]  cfg_wdata_i,
  cipher_in_if.sink    in_i,
  cipher_out_if.source out_o
);
  import skcb_pkg::*;

  cmd_t cmd;   // controller -> datapath command

  skcb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  skcb_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .data_in_i   (in_i.data_in),
    .last_in_i   (in_i.last_in),
    .data_out_o  (out_o.data_out),
    .last_out_o  (out_o.last_out)
  );

endmodule

FILE: bench/keystream_checker.sv
`timescale 1ns / 1ps
// Checker for the keyed byte cipher: tracks the key and run position, predicts
// every output beat and compares it with what the block sends.
// Depends on skcb_pkg and the channel interfaces in skcb_if.
module keystream_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [63:0]  cfg_wdata_i,
  cipher_in_if         in_mon,
  cipher_out_if        out_mon,
  output int           mismatch_count_o,
  output int           pending_count_o
);
  import skcb_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } plain_beat_t;

  logic [63:0]            key_q;
  logic [INDEX_WIDTH-1:0] run_pos_q;
  plain_beat_t            plain_q[$];
  int                     mismatch_total = 0;

  assign mismatch_count_o = mismatch_total;

  // splitmix64 finalizer; products keep the low 64 bits
  function automatic logic [63:0] avalanche64(input logic [63:0] z);
    logic [63:0] t;
    t = (z ^ (z >> 30)) * MIX_MUL_A;
    t = (t ^ (t >> 27)) * MIX_MUL_B;
    return t ^ (t >> 31);
  endfunction

  function automatic plain_beat_t decrypt_beat(input logic [63:0] key,
                                               input logic [INDEX_WIDTH-1:0] pos,
                                               input logic [7:0] data,
                                               input logic last);
    logic [63:0] w;
    logic [2:0]  lane_a;
    logic [2:0]  lane_b;
    logic [2:0]  lane_c;
    logic [7:0]  mask;
    logic [7:0]  shifted;
    plain_beat_t r;
    w       = avalanche64(key ^ (64'(pos) * GOLDEN_GAMMA));
    lane_a  = pos[2:0];
    lane_b  = pos[2:0] + 3'd3;
    lane_c  = pos[2:0] + 3'd7;
    mask    = w[8*lane_a +: 8] ^ w[8*lane_b +: 8] ^ w[8*lane_c +: 8];
    shifted = data + key[15:8] - (key[7:0] ^ KEY_BYTE_FLIP);
    r.data  = shifted ^ mask;
    r.last  = last;
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_total++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    plain_beat_t exp_b;
    if (!rst_ni) begin
      key_q           <= '0;
      run_pos_q       <= '0;
      plain_q.delete();
      pending_count_o <= 0;
    end else begin
      // output first: a beat leaving now belongs to an earlier input
      if (out_mon.valid && out_mon.ready) begin
        if (plain_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected beat data=%02h last=%0b",
                                  out_mon.data_out, out_mon.last_out));
        end else begin
          exp_b = plain_q.pop_front();
          if (out_mon.data_out !== exp_b.data)
            flag_mismatch($sformatf("data %02h, want %02h", out_mon.data_out, exp_b.data));
          if (out_mon.last_out !== exp_b.last)
            flag_mismatch($sformatf("last %0b, want %0b", out_mon.last_out, exp_b.last));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        plain_q.push_back(decrypt_beat(key_q, run_pos_q, in_mon.data_in, in_mon.last_in));
        run_pos_q <= in_mon.last_in ? '0 : run_pos_q + INDEX_WIDTH'(1);
      end
      if (cfg_we_i) begin
        key_q <= cfg_wdata_i;
      end
      pending_count_o <= plain_q.size();
    end
  end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Top of the cipher bench: clock, reset, key writes and byte stimulus, with
// random stalls on both channels. Depends on skcb_pkg, skcb_if, the cipher
// top and keystream_checker, which does all prediction and comparison.
module tb_top;
  import skcb_pkg::*;

  // No beat on either channel for this long means the block is hung. The
  // slowest legit gap is one byte's computation plus a random output stall.
  localparam int QUIET_LIMIT = 2000;
  // Settle time after the last expected beat, a bit over the latency.
  localparam int DRAIN_TAIL  = 20;
  localparam int PHASE_BEATS = 20;
  localparam int LONG_RUN    = 260;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [63:0] cfg_wdata;
  int          stall_pct = 37;  // percent of cycles each side idles
  int          run_left  = 0;   // beats left in the current random run
  int          mismatches;
  int          in_flight;

  cipher_in_if  in_ch();
  cipher_out_if out_ch();

  splitmix_keyed_byte_cipher_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  keystream_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_mon           (in_ch),
    .out_mon          (out_ch),
    .mismatch_count_o (mismatches),
    .pending_count_o  (in_flight)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Receiver: back-pressure drawn fresh every cycle, independent of valid.
  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Offer one beat after a random gap, return at the edge that takes it.
  // Valid is left high so a following beat goes out back to back.
  task automatic send_byte(input logic [7:0] data, input logic last);
    while ($urandom_range(0, 99) < stall_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.data_in <= data;
    in_ch.last_in <= last;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Hold the sender until every predicted beat is out, then write the key.
  // Each input gives exactly one output, so an empty queue means idle.
  task automatic drain_and_write_key(input logic [63:0] key);
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (in_flight != 0) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= key;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Random runs of 1..12 beats, with a stray early last now and then.
  // Runs carry over between calls, so key writes also land mid-run.
  task automatic random_runs(input int beats);
    logic last_b;
    for (int n = 0; n < beats; n++) begin
      if (run_left == 0) run_left = $urandom_range(1, 12);
      run_left--;
      last_b = (run_left == 0) || ($urandom_range(0, 19) == 0);
      if (last_b) run_left = 0;
      send_byte(8'($urandom_range(0, 255)), last_b);
    end
  endtask

  initial begin
    logic [7:0]  corner_bytes[10];
    logic [63:0] phase_key;
    int          spins;
    corner_bytes  = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01,
                      8'hFE, 8'h55, 8'hAA, 8'h0F, 8'hF0};
    in_ch.valid   <= 1'b0;
    in_ch.data_in <= '0;
    in_ch.last_in <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    rst_ni        <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset key of zero: one-beat runs at both data extremes,
    // then a ten-beat run so the lane pick wraps past byte 7.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    for (int k = 0; k < 10; k++) send_byte(corner_bytes[k], k == 9);

    // All-ones key, then a key change in the middle of a run: the position
    // must carry on across the write.
    drain_and_write_key('1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h5A, 1'b0);
    drain_and_write_key(64'h0123_4567_89AB_CDEF);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'hC3, 1'b1);

    // Random phases, each under its own key. Phase 3 runs with no stalls on
    // either side; phase 5 is one long run so the position climbs past 255.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin
          phase_key = '1;
        end
        2: begin
          // low key byte equal to the flip constant: subtract term is zero
          phase_key      = {$urandom, $urandom};
          phase_key[7:0] = KEY_BYTE_FLIP;
        end
        4: begin
          phase_key = 64'h8000_0000_0000_0000;
        end
        7: begin
          phase_key = '0;
        end
        default: begin
          phase_key = {$urandom, $urandom};
        end
      endcase
      drain_and_write_key(phase_key);
      stall_pct <= (p == 3) ? 0 : 37;
      if (p == 5) begin
        for (int k = 0; k < LONG_RUN; k++)
          send_byte(8'($urandom_range(0, 255)), k == LONG_RUN - 1);
        run_left = 0;
      end else begin
        random_runs(PHASE_BEATS);
      end
    end

    // Wind down: let every predicted beat come out, then settle.
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    spins = 0;
    while (in_flight != 0 && spins < QUIET_LIMIT) begin
      @(posedge clk_i);
      spins++;
    end
    repeat (DRAIN_TAIL) @(posedge clk_i);
    if (in_flight != 0) $display("%0d decrypted beats never came out", in_flight);
    if (mismatches == 0 && in_flight == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: any beat on either channel resets the count.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("no beat for %0d cycles, giving up", QUIET_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

endmodule
